>>> hw/rtl/mrw_pkg.sv
package mrw_pkg;

  // field widths
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned DacWidth    = 12;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 32;
  localparam int unsigned FracWidth   = 24;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] REG_AMBIENT_INCREMENT = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_INNOVATION_GAIN   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_TARGET_SPREAD     = 2'd2;

  // direction tag of the carried fraction
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_REV,
    ST_MUL_GAIN,
    ST_MUL_SPREAD,
    ST_FINISH
  } state_t;

endpackage

>>> hw/rtl/mrw_channels.sv
// sample request channel
interface mrw_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] random_sample;

  modport source (output valid, output random_sample, input ready);
  modport sink (input valid, input random_sample, output ready);
endinterface

// result request channel
interface mrw_result_if;
  logic               valid;
  logic               ready;
  logic [11:0]        dac_value;
  logic signed [15:0] walk_value;

  modport source (output valid, output dac_value, output walk_value, input ready);
  modport sink (input valid, input dac_value, input walk_value, output ready);
endinterface

>>> hw/rtl/mean_reverting_random_walk.sv
// Mean-reverting random walk, one result per random sample.
//
// Channels: sample_ch (sink) takes one signed Q1.15 random sample per request;
// result_ch (source) returns the new walk value and its 12-bit DAC code.
// cfg_wr_en/cfg_index/cfg_data write ambient_increment (0), innovation_gain (1)
// and target_spread (2); other indexes are ignored. Write only while idle.
//
// Timing: a sample is accepted in the idle state, then the shared 18x26
// multiplier is used three times (level times alpha, sample times gain,
// scaled sample times spread) and a final step saturates and adds. The
// result is registered as FINISH completes, after MUL_REV, MUL_GAIN and
// MUL_SPREAD; sample_ch.ready is high only while the sequencer is idle.
//
// Stall: the result sits in an output register; the next sample is accepted
// while it waits, but that sample's final step holds until the register frees.
//
// Reset: the walk level, the carried fraction and its direction clear, the
// registers take their reset values and no result is pending.
module mean_reverting_random_walk (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [mrw_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  logic [mrw_pkg::CfgWidth-1:0]      cfg_data,
  mrw_sample_if.sink                        sample_ch,
  mrw_result_if.source                      result_ch
);
  import mrw_pkg::*;

  // configuration registers
  logic [31:0] ambient_increment;
  logic [15:0] innovation_gain;
  logic [15:0] target_spread;

  // walk state
  logic signed [15:0]   walk_level;
  logic [FracWidth-1:0] fraction_carry;
  logic [1:0]           carry_sign;

  // sequencer and datapath registers
  state_t             state;
  state_t             state_next;
  logic signed [15:0] sample;
  logic signed [43:0] prod;
  logic signed [15:0] level_rev;

  // output register
  logic               out_valid;
  logic [11:0]        out_dac;
  logic signed [15:0] out_walk;

  // shared multiplier operands
  logic signed [17:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [43:0] mul_p;

  // reversion datapath
  logic [32:0]          alpha_sum;
  logic [24:0]          alpha;
  logic [16:0]          mag;
  logic [1:0]           dir;
  logic [FracWidth-1:0] frac_eff;
  logic [40:0]          wsum;
  logic [16:0]          move;
  logic [16:0]          rem;

  // final step
  logic signed [15:0] inno;
  logic signed [16:0] level_sum;
  logic signed [15:0] level_new;
  logic               out_free;
  logic               finish_go;

  function automatic logic signed [15:0] sat16_29(input logic signed [28:0] x);
    if (x < -29'sd32768) begin
      return -16'sd32768;
    end else if (x > 29'sd32767) begin
      return 16'sd32767;
    end
    return x[15:0];
  endfunction

  function automatic logic signed [15:0] sat16_17(input logic signed [16:0] x);
    if (x < -17'sd32768) begin
      return -16'sd32768;
    end else if (x > 17'sd32767) begin
      return 16'sd32767;
    end
    return x[15:0];
  endfunction

  // alpha from the ambient increment, at least one
  assign alpha_sum = {1'b0, ambient_increment} + 33'd128;
  always_comb begin
    alpha = alpha_sum[32:8];
    if (alpha == 25'd0) begin
      alpha = 25'd1;
    end
  end

  // magnitude and direction of the stored level
  assign mag = walk_level[15] ? (17'd0 - {walk_level[15], walk_level})
                              : {1'b0, walk_level};
  assign dir = walk_level[15] ? DIR_NEG : DIR_POS;
  assign frac_eff = (carry_sign == dir) ? fraction_carry : '0;

  // shrink the magnitude by the integer part of level times alpha plus the carried fraction
  assign wsum = prod[40:0] + {17'd0, frac_eff};
  assign move = wsum[40:24];
  assign rem  = (move >= mag) ? 17'd0 : (mag - move);

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_MUL_REV: begin
        mul_a = {1'b0, mag};
        mul_b = {1'b0, alpha};
      end
      ST_MUL_GAIN: begin
        mul_a = {{2{sample[15]}}, sample};
        mul_b = {10'd0, innovation_gain};
      end
      ST_MUL_SPREAD: begin
        mul_a = {prod[31], prod[31:15]};
        mul_b = {10'd0, target_spread};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // innovation add with saturation
  assign inno      = sat16_29(prod[43:15]);
  assign level_sum = {level_rev[15], level_rev} + {inno[15], inno};
  assign level_new = sat16_17(level_sum);

  assign out_free  = !out_valid || result_ch.ready;
  assign finish_go = (state == ST_FINISH) && out_free;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_ch.valid) begin
          state_next = ST_MUL_REV;
        end
      end
      ST_MUL_REV:    state_next = ST_MUL_GAIN;
      ST_MUL_GAIN:   state_next = ST_MUL_SPREAD;
      ST_MUL_SPREAD: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign sample_ch.ready = (state == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ambient_increment <= '0;
      innovation_gain   <= 16'd32768;
      target_spread     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_AMBIENT_INCREMENT: ambient_increment <= cfg_data;
        REG_INNOVATION_GAIN:   innovation_gain   <= cfg_data[15:0];
        REG_TARGET_SPREAD:     target_spread     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (sample_ch.valid && sample_ch.ready) begin
      sample <= sample_ch.random_sample;
    end
    if (state == ST_MUL_REV || state == ST_MUL_GAIN || state == ST_MUL_SPREAD) begin
      prod <= mul_p;
    end
  end

  // reversion result and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_level     <= '0;
      fraction_carry <= '0;
      carry_sign     <= DIR_NONE;
      level_rev      <= '0;
    end else begin
      if (state == ST_MUL_GAIN) begin
        if (walk_level == 16'sd0 || rem == 17'd0) begin
          fraction_carry <= '0;
          carry_sign     <= DIR_NONE;
          level_rev      <= '0;
        end else begin
          fraction_carry <= wsum[23:0];
          carry_sign     <= dir;
          level_rev      <= (dir == DIR_POS) ? rem[15:0] : (16'd0 - rem[15:0]);
        end
      end
      if (finish_go) begin
        walk_level <= level_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_walk <= level_new;
      out_dac  <= {~level_new[15], level_new[14:4]};
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.dac_value  = out_dac;
  assign result_ch.walk_value = out_walk;

endmodule

>>> hw/rtl/mrw_checker.sv
module mrw_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [11:0]        dac_value,
  input logic signed [15:0] walk_value
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(walk_value))
    else $error("result dropped or changed while stalled");

  // one sample at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while busy");

  // no result the cycle right after a sample is taken
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too early");

  // dac code is the offset walk value
  a_dac_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> dac_value == {~walk_value[15], walk_value[14:4]})
    else $error("dac code does not match walk value");

  // reset leaves nothing pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind mean_reverting_random_walk mrw_checker u_mrw_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample_ch.valid),
  .in_ready   (sample_ch.ready),
  .out_valid  (result_ch.valid),
  .out_ready  (result_ch.ready),
  .dac_value  (result_ch.dac_value),
  .walk_value (result_ch.walk_value)
);
